// ===== rtl/odo_pkg.sv =====
// Shared types, register codes and fixed-point constants for the
// differential-drive odometry core. No dependencies.
`default_nettype none
package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 32;

  // register indexes on the write port
  localparam logic [2:0] REG_LEFT_MAX    = 3'd0;
  localparam logic [2:0] REG_RIGHT_MAX   = 3'd1;
  localparam logic [2:0] REG_HEAD_GAIN   = 3'd2;
  localparam logic [2:0] REG_TRAVEL_GAIN = 3'd3;
  localparam logic [2:0] REG_SNAP_WINDOW = 3'd4;

  localparam logic [14:0] LEFT_MAX_RST    = 15'd1000;
  localparam logic [14:0] RIGHT_MAX_RST   = 15'd1000;
  localparam logic [23:0] HEAD_GAIN_RST   = 24'd65536;
  localparam logic [23:0] TRAVEL_GAIN_RST = 24'd65536;
  localparam logic [3:0]  SNAP_WINDOW_RST = 4'd2;

  localparam logic ITEM_SAMPLE = 1'b0;
  localparam logic ITEM_TICK   = 1'b1;

  // Q2.30 angle constants
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

  localparam logic [26:0] HEAD_LIMIT   = 27'h7FF_FFFF;
  localparam logic [31:0] TRAVEL_LIMIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } odo_item_t;

  typedef struct packed {
    logic [14:0] left_max;
    logic [14:0] right_max;
    logic [23:0] head_gain;
    logic [23:0] travel_gain;
    logic [3:0]  snap_window;
  } odo_cfg_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/odo_front.sv =====
// Front end: snaps measured pulse counts to their setpoints when within the
// snap window and packs the request into a queue entry. Depends on odo_pkg.
`default_nettype none
module odo_front (
  input  wire logic               req_type,
  input  wire logic signed [15:0] left_pulses,
  input  wire logic signed [15:0] right_pulses,
  input  wire logic signed [15:0] left_target,
  input  wire logic signed [15:0] right_target,
  input  wire logic [3:0]         snap_window,
  output odo_pkg::odo_item_t      item
);
  import odo_pkg::*;

  function automatic logic signed [15:0] snap(input logic signed [15:0] meas,
                                              input logic signed [15:0] tgt,
                                              input logic [3:0] win);
    logic signed [16:0] d;
    logic [16:0]        mag;
    d   = 17'(tgt) - 17'(meas);
    mag = d[16] ? 17'(-d) : 17'(d);
    return (mag <= 17'(win)) ? tgt : meas;
  endfunction

  always_comb begin
    item.kind  = req_type;
    item.left  = snap(left_pulses, left_target, snap_window);
    item.right = snap(right_pulses, right_target, snap_window);
  end

endmodule
`default_nettype wire

// ===== rtl/odo_fifo.sv =====
// Two-entry register queue between front and back end.
// No dependencies.
`default_nettype none
module odo_fifo #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      dout,
  output logic                  full,
  output logic                  empty
);
  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      if (wr && !rd) count <= count + 2'd1;
      else if (rd && !wr) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/odo_back.sv =====
// Back end: wheel counters, left-scale divider, heading and travel gains,
// CORDIC rotation and pose update with a result register. Depends on odo_pkg.
`default_nettype none
module odo_back #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF,
  parameter int ACC_WIDTH    = odo_pkg::ACC_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire odo_pkg::odo_cfg_t  cfg,
  input  wire logic               item_valid,
  input  wire odo_pkg::odo_item_t item,
  output logic                    item_pop,
  input  wire logic               res_pop,
  output logic                    res_empty,
  output logic signed [31:0]      pos_x_out,
  output logic signed [31:0]      pos_y_out,
  output logic signed [31:0]      heading_out
);
  import odo_pkg::*;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_NUM_MUL  = 5'd1;
  localparam logic [4:0] ST_NUM_LOAD = 5'd2;
  localparam logic [4:0] ST_DIV      = 5'd3;
  localparam logic [4:0] ST_MAP      = 5'd4;
  localparam logic [4:0] ST_HEAD_MUL = 5'd5;
  localparam logic [4:0] ST_HEAD_SAT = 5'd6;
  localparam logic [4:0] ST_DIST_SAT = 5'd7;
  localparam logic [4:0] ST_FOLD     = 5'd8;
  localparam logic [4:0] ST_CORDIC   = 5'd9;
  localparam logic [4:0] ST_SIGN     = 5'd10;
  localparam logic [4:0] ST_X_LO     = 5'd11;
  localparam logic [4:0] ST_X_HI     = 5'd12;
  localparam logic [4:0] ST_X_SUM    = 5'd13;
  localparam logic [4:0] ST_Y_LO     = 5'd14;
  localparam logic [4:0] ST_Y_HI     = 5'd15;
  localparam logic [4:0] ST_Y_SUM    = 5'd16;
  localparam logic [4:0] ST_EMIT     = 5'd17;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
  localparam logic [5:0] LAST_DIV  = 6'd32;

  logic [4:0] state;

  logic [ACC_WIDTH-1:0] left_total, right_total, left_prev, right_prev;
  logic signed [15:0]   cur_left, cur_right;
  logic signed [ACC_WIDTH-1:0] diff;
  logic signed [ACC_WIDTH:0]   sum;

  // shared unsigned multiplier
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;

  // divider
  logic [32:0] num;
  logic [15:0] rem;
  logic        map_neg;
  logic [5:0]  div_cnt;

  logic signed [31:0] heading;
  logic signed [32:0] travel;
  logic signed [34:0] zr;
  logic signed [33:0] cx, cy;
  logic signed [31:0] cz;
  logic               fold_neg;
  logic [4:0]         step;

  // shared signed multiplier
  logic signed [17:0] smul_b;
  logic signed [50:0] sp, sacc;

  logic signed [31:0] pos_x, pos_y;
  logic               out_valid;
  logic               emit_fire;

  // combinational helpers
  logic [14:0]        lm_eff;
  logic [15:0]        dvs;
  logic signed [16:0] lsum;
  logic [16:0]        lmag;
  logic [16:0]        rshift;
  logic [ACC_WIDTH-1:0] d_right, d_left, dmag;
  logic [ACC_WIDTH:0]   smag;
  logic [26:0]        dmag_c;
  logic [31:0]        smag_c;
  logic [26:0]        head_p;
  logic [31:0]        head_w;
  logic [31:0]        dist_p;
  logic signed [34:0] zh, zred, zfold;
  logic signed [33:0] xs, ys;
  logic signed [31:0] at;
  logic signed [33:0] q_s, mapped;
  logic signed [66:0] tot, nv;
  logic signed [31:0] old_pos, new_pos;

  assign lm_eff = (cfg.left_max == 15'd0) ? 15'd1 : cfg.left_max;
  assign dvs    = {lm_eff, 1'b0};
  assign lsum   = 17'(cur_left) + $signed({2'b00, lm_eff});
  assign lmag   = lsum[16] ? 17'(-lsum) : 17'(lsum);
  assign rshift = {rem, num[32]};

  assign d_right = right_total - right_prev;
  assign d_left  = left_total - left_prev;
  assign dmag    = diff[ACC_WIDTH-1] ? ACC_WIDTH'(-diff) : ACC_WIDTH'(diff);
  assign smag    = sum[ACC_WIDTH] ? (ACC_WIDTH+1)'(-sum) : (ACC_WIDTH+1)'(sum);
  assign dmag_c  = (64'(dmag) > 64'(HEAD_LIMIT)) ? HEAD_LIMIT : 27'(dmag);
  assign smag_c  = (64'(smag) > 64'(TRAVEL_LIMIT)) ? TRAVEL_LIMIT : 32'(smag);
  assign head_p  = (mul_p > 56'(HEAD_LIMIT)) ? HEAD_LIMIT : mul_p[26:0];
  assign head_w  = {1'b0, head_p, 4'b0000};
  assign dist_p  = (mul_p > 56'(TRAVEL_LIMIT)) ? TRAVEL_LIMIT : mul_p[31:0];

  assign zh = $signed({heading[31], heading, 2'b00});

  always_comb begin
    if (zh > Q30_PI) zred = zh - Q30_TWO_PI;
    else if (zh < -Q30_PI) zred = zh + Q30_TWO_PI;
    else zred = zh;
    if (zr > Q30_HALF_PI) zfold = zr - Q30_PI;
    else if (zr < -Q30_HALF_PI) zfold = zr + Q30_PI;
    else zfold = zr;
  end

  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = $signed(atan_q30(step));

  assign q_s    = map_neg ? -$signed({1'b0, num}) : $signed({1'b0, num});
  assign mapped = q_s - $signed({19'd0, cfg.right_max});

  assign tot     = (67'(sp) <<< 16) + 67'(sacc);
  assign old_pos = (state == ST_X_SUM) ? pos_x : pos_y;
  assign nv      = (tot >>> 30) + 67'(old_pos);
  always_comb begin
    if (nv > 67'sd2147483647) new_pos = 32'sh7FFF_FFFF;
    else if (nv < -67'sd2147483648) new_pos = 32'sh8000_0000;
    else new_pos = 32'(nv);
  end

  always_comb begin
    case (state)
      ST_NUM_MUL: begin
        mul_a = 32'(lmag);
        mul_b = 24'({cfg.right_max, 1'b0});
      end
      ST_HEAD_MUL: begin
        mul_a = 32'(dmag_c);
        mul_b = cfg.head_gain;
      end
      default: begin
        mul_a = smag_c;
        mul_b = cfg.travel_gain;
      end
    endcase
    case (state)
      ST_X_LO: smul_b = $signed({2'b00, cx[15:0]});
      ST_X_HI: smul_b = cx[33:16];
      ST_Y_LO: smul_b = $signed({2'b00, cy[15:0]});
      default: smul_b = cy[33:16];
    endcase
  end

  assign item_pop    = (state == ST_IDLE) && item_valid;
  assign res_empty   = !out_valid;
  assign emit_fire   = (state == ST_EMIT) && (!out_valid || res_pop);

  // datapath registers
  always_ff @(posedge clk) begin
    mul_p <= 56'(mul_a) * 56'(mul_b);
    sp    <= travel * smul_b;
    case (state)
      ST_IDLE: begin
        cur_left  <= item.left;
        cur_right <= item.right;
        diff      <= $signed(right_total - left_total);
        sum       <= (ACC_WIDTH+1)'($signed(d_right)) + (ACC_WIDTH+1)'($signed(d_left));
      end
      ST_NUM_MUL: map_neg <= lsum[16];
      ST_NUM_LOAD: begin
        num     <= mul_p[32:0];
        rem     <= 16'd0;
        div_cnt <= 6'd0;
      end
      ST_DIV: begin
        if (rshift >= 17'(dvs)) begin
          rem <= 16'(rshift - 17'(dvs));
          num <= {num[31:0], 1'b1};
        end else begin
          rem <= rshift[15:0];
          num <= {num[31:0], 1'b0};
        end
        div_cnt <= div_cnt + 6'd1;
      end
      ST_HEAD_SAT: heading <= diff[ACC_WIDTH-1] ? -$signed(head_w) : $signed(head_w);
      ST_DIST_SAT: begin
        travel <= sum[ACC_WIDTH] ? -$signed({1'b0, dist_p}) : $signed({1'b0, dist_p});
        zr     <= zred;
      end
      ST_FOLD: begin
        fold_neg <= (zr > Q30_HALF_PI) || (zr < -Q30_HALF_PI);
        cz       <= 32'(zfold);
        cx       <= CORDIC_K;
        cy       <= 34'sd0;
        step     <= 5'd0;
      end
      ST_CORDIC: begin
        if (!cz[31]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
        step <= step + 5'd1;
      end
      ST_SIGN: begin
        if (fold_neg) begin
          cx <= -cx;
          cy <= -cy;
        end
      end
      ST_X_HI, ST_Y_HI: sacc <= sp;
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      left_total  <= '0;
      right_total <= '0;
      left_prev   <= '0;
      right_prev  <= '0;
      pos_x       <= 32'sd0;
      pos_y       <= 32'sd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.kind == ITEM_TICK) begin
              left_prev  <= left_total;
              right_prev <= right_total;
              state      <= ST_HEAD_MUL;
            end else begin
              state <= ST_NUM_MUL;
            end
          end
        end
        ST_NUM_MUL: begin
          right_total <= right_total + ACC_WIDTH'(cur_right);
          state       <= ST_NUM_LOAD;
        end
        ST_NUM_LOAD: state <= ST_DIV;
        ST_DIV: if (div_cnt == LAST_DIV) state <= ST_MAP;
        ST_MAP: begin
          left_total <= left_total + ACC_WIDTH'(mapped);
          state      <= ST_IDLE;
        end
        ST_HEAD_MUL: state <= ST_HEAD_SAT;
        ST_HEAD_SAT: state <= ST_DIST_SAT;
        ST_DIST_SAT: state <= ST_FOLD;
        ST_FOLD:     state <= ST_CORDIC;
        ST_CORDIC:   if (step == LAST_STEP) state <= ST_SIGN;
        ST_SIGN:     state <= ST_X_LO;
        ST_X_LO:     state <= ST_X_HI;
        ST_X_HI:     state <= ST_X_SUM;
        ST_X_SUM: begin
          pos_x <= new_pos;
          state <= ST_Y_LO;
        end
        ST_Y_LO:     state <= ST_Y_HI;
        ST_Y_HI:     state <= ST_Y_SUM;
        ST_Y_SUM: begin
          pos_y <= new_pos;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the result register is free
          if (emit_fire) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (res_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      pos_x_out   <= pos_x;
      pos_y_out   <= pos_y;
      heading_out <= heading;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/differential_drive_odometry_core.sv =====
// Differential-drive odometry core: a wheel sample passes through the
// 33-step left-scale divider in the back end; a pose tick passes through
// the one-step-per-cycle CORDIC of CORDIC_STEPS steps and the split 33x18
// multiplier. A two-entry queue sits in front of the back end and one
// result register behind it, so requests can still be queued while a pose
// waits to be popped. Registers may be written only while idle.
// Depends on odo_pkg, odo_front, odo_fifo, odo_back.
`default_nettype none
module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF,
  parameter int ACC_WIDTH    = odo_pkg::ACC_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               req_type,
  input  wire logic signed [15:0] left_pulses,
  input  wire logic signed [15:0] right_pulses,
  input  wire logic signed [15:0] left_target,
  input  wire logic signed [15:0] right_target,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      pos_x_out,
  output logic signed [31:0]      pos_y_out,
  output logic signed [31:0]      heading_out,
  input  wire logic               wr_en,
  input  wire logic [2:0]         wr_index,
  input  wire logic [23:0]        wr_data
);
  import odo_pkg::*;

  odo_cfg_t  cfg;
  odo_item_t front_item, queue_item;
  logic      queue_empty, item_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_max    <= LEFT_MAX_RST;
      cfg.right_max   <= RIGHT_MAX_RST;
      cfg.head_gain   <= HEAD_GAIN_RST;
      cfg.travel_gain <= TRAVEL_GAIN_RST;
      cfg.snap_window <= SNAP_WINDOW_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEFT_MAX:    cfg.left_max    <= wr_data[14:0];
        REG_RIGHT_MAX:   cfg.right_max   <= wr_data[14:0];
        REG_HEAD_GAIN:   cfg.head_gain   <= wr_data;
        REG_TRAVEL_GAIN: cfg.travel_gain <= wr_data;
        REG_SNAP_WINDOW: cfg.snap_window <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  odo_front u_front (
    .req_type     (req_type),
    .left_pulses  (left_pulses),
    .right_pulses (right_pulses),
    .left_target  (left_target),
    .right_target (right_target),
    .snap_window  (cfg.snap_window),
    .item         (front_item)
  );

  odo_fifo #(.WIDTH($bits(odo_item_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push && !full),
    .din   (front_item),
    .rd    (item_pop),
    .dout  (queue_item),
    .full  (full),
    .empty (queue_empty)
  );

  odo_back #(.CORDIC_STEPS(CORDIC_STEPS), .ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (!queue_empty),
    .item        (queue_item),
    .item_pop    (item_pop),
    .res_pop     (pop),
    .res_empty   (empty),
    .pos_x_out   (pos_x_out),
    .pos_y_out   (pos_y_out),
    .heading_out (heading_out)
  );

endmodule
`default_nettype wire

// ===== rtl/odo_checker.sv =====
// Port-level checks for the odometry core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module odo_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] pos_x_out,
  input wire logic [31:0] heading_out
);
  // a waiting pose holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(pos_x_out) && $stable(heading_out))
    else $error("pose changed before pop");

  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queue not clear after reset");

  // heading is a Q3.24 product shifted up by four
  a_head_lsb: assert property (@(posedge clk) disable iff (rst)
    !empty |-> heading_out[3:0] == 4'd0)
    else $error("heading low bits set");

  a_head_sym: assert property (@(posedge clk) disable iff (rst)
    !empty |-> heading_out != 32'h8000_0000)
    else $error("heading saturation not symmetric");
endmodule

bind differential_drive_odometry_core odo_checker u_odo_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .pos_x_out   (pos_x_out),
  .heading_out (heading_out)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for differential_drive_odometry_core: random and directed wheel samples and
// pose ticks, checked against a built-in fixed-point odometry predictor.
// Depends on odo_pkg and the core RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import odo_pkg::*;

  // index with no register behind it
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hd;
  } pose_t;

  class pose_board;
    logic [14:0] lmax, rmax;
    logic [23:0] hgain, tgain;
    logic [3:0]  snapw;
    logic [31:0] ltot, rtot, lprev, rprev;
    logic signed [31:0] px, py, hd;
    pose_t pending[$];
    int errors;
    int ticks;

    function void clear();
      lmax = LEFT_MAX_RST; rmax = RIGHT_MAX_RST; hgain = HEAD_GAIN_RST;
      tgain = TRAVEL_GAIN_RST; snapw = SNAP_WINDOW_RST;
      ltot = 0; rtot = 0; lprev = 0; rprev = 0; px = 0; py = 0; hd = 0;
      errors = 0; ticks = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_LEFT_MAX:    lmax = val[14:0];
        REG_RIGHT_MAX:   rmax = val[14:0];
        REG_HEAD_GAIN:   hgain = val;
        REG_TRAVEL_GAIN: tgain = val;
        REG_SNAP_WINDOW: snapw = val[3:0];
        default: ;
      endcase
    endfunction

    function longint snap_to(longint m, longint t);
      longint d;
      d = t - m;
      if (d < 0) d = -d;
      return (d <= snapw) ? t : m;
    endfunction

    function longint sat_gain(longint v, longint unsigned g, longint unsigned lim);
      longint unsigned mag, p;
      mag = (v < 0) ? -v : v;
      if (g == 0 || mag == 0) return 0;
      if (mag > lim) p = lim;
      else begin
        p = mag * g;
        if (p > lim) p = lim;
      end
      return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // arithmetic shift of a 64-bit signed value rounds toward minus infinity
    function void rotate(logic signed [31:0] ang, output longint c, output longint s);
      longint z, x, y, nx, at;
      bit flip;
      z = longint'(ang) * 4;
      x = CORDIC_K; y = 0; flip = 0;
      while (z > Q30_PI) z -= Q30_TWO_PI;
      while (z < -Q30_PI) z += Q30_TWO_PI;
      if (z > Q30_HALF_PI) begin
        z -= Q30_PI; flip = 1;
      end else if (z < -Q30_HALF_PI) begin
        z += Q30_PI; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        at = longint'(atan_table(i));
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= at;
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += at;
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function logic [31:0] atan_table(int i);
      logic [31:0] t [16];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF};
      return t[i];
    endfunction

    function void note_item(logic kind, logic signed [15:0] lp, logic signed [15:0] rp,
                            logic signed [15:0] lt, logic signed [15:0] rt);
      longint l, r, lm, rm, mapped, diff, sum, trav, c, s;
      logic signed [31:0] dr, dl, df;
      pose_t p;
      if (kind == ITEM_SAMPLE) begin
        l = snap_to(lp, lt);
        r = snap_to(rp, rt);
        lm = (lmax == 0) ? 1 : lmax;
        rm = rmax;
        mapped = (l + lm) * (2 * rm) / (2 * lm) - rm;
        ltot = ltot + mapped[31:0];
        rtot = rtot + r[31:0];
      end else begin
        df = rtot - ltot;
        dr = rtot - rprev;
        dl = ltot - lprev;
        diff = df;
        sum = longint'(dr) + longint'(dl);
        hd = clip32(sat_gain(diff, hgain, 64'd134217727) * 16);
        lprev = ltot; rprev = rtot;
        trav = sat_gain(sum, tgain, 64'hFFFF_FFFF);
        rotate(hd, c, s);
        px = clip32(longint'(px) + ((trav * c) >>> 30));
        py = clip32(longint'(py) + ((trav * s) >>> 30));
        p.x = px; p.y = py; p.hd = hd;
        pending.push_back(p);
      end
    endfunction

    function void check_pose(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] h);
      pose_t e;
      ticks++;
      if (pending.size() == 0) begin
        $error("pose beat with nothing expected: x=%0d y=%0d heading=%0d", x, y, h);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $error("pos_x_out expected %0d got %0d", e.x, x); errors++;
      end
      if (y !== e.y) begin
        $error("pos_y_out expected %0d got %0d", e.y, y); errors++;
      end
      if (h !== e.hd) begin
        $error("heading_out expected %0d got %0d", e.hd, h); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, req_type = 0, wr_en = 0;
  logic signed [15:0] left_pulses = 0, right_pulses = 0, left_target = 0, right_target = 0;
  logic [2:0] wr_index = 0;
  logic [23:0] wr_data = 0;
  logic full, empty;
  logic signed [31:0] pos_x_out, pos_y_out, heading_out;

  pose_board board;
  int send_idle, recv_stall;
  int quiet_cycles;
  int items_sent;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  differential_drive_odometry_core u_top (
    .clk, .rst, .push, .full, .req_type, .left_pulses, .right_pulses, .left_target,
    .right_target, .empty, .pop, .pos_x_out, .pos_y_out, .heading_out,
    .wr_en, .wr_index, .wr_data
  );

  // receiver: decide pop per cycle, check on the accepting edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) board.check_pose(pos_x_out, pos_y_out, heading_out);
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // push stays high from one beat to the next; idling or drain drops it
  task automatic send_item(logic kind, logic signed [15:0] lp, logic signed [15:0] rp,
                           logic signed [15:0] lt, logic signed [15:0] rt);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; req_type <= kind;
    left_pulses <= lp; right_pulses <= rp; left_target <= lt; right_target <= rt;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_item(kind, lp, rp, lt, rt);
    items_sent++;
  endtask

  task automatic drain();
    push <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_LEFT_MAX, extreme ? ($urandom_range(1) ? 24'd32767 : 24'd0)
                                    : 24'($urandom_range(2000, 1)));
    write_reg(REG_RIGHT_MAX, extreme ? ($urandom_range(1) ? 24'd32767 : 24'd1)
                                     : 24'($urandom_range(2000, 1)));
    write_reg(REG_HEAD_GAIN, extreme ? ($urandom_range(1) ? 24'hFFFFFF : 24'd0)
                                     : 24'($urandom_range(200000)));
    write_reg(REG_TRAVEL_GAIN, extreme ? ($urandom_range(1) ? 24'hFFFFFF : 24'd0)
                                       : 24'($urandom_range(200000)));
    write_reg(REG_SNAP_WINDOW, extreme ? ($urandom_range(1) ? 24'd15 : 24'd0)
                                       : 24'($urandom_range(15)));
  endtask

  // mostly small motion near setpoints; sometimes full-range noise or a pose tick
  task automatic random_item();
    logic signed [15:0] lp, rp, lt, rt;
    if ($urandom_range(4) == 0) begin
      send_item(ITEM_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      return;
    end
    if ($urandom_range(7) == 0) begin
      lp = 16'($urandom); rp = 16'($urandom); lt = 16'($urandom); rt = 16'($urandom);
    end else begin
      lt = $signed(16'($urandom_range(2000))) - 16'sd1000;
      rt = $signed(16'($urandom_range(2000))) - 16'sd1000;
      lp = lt + $signed(16'($urandom_range(40))) - 16'sd20;
      rp = rt + $signed(16'($urandom_range(40))) - 16'sd20;
    end
    send_item(ITEM_SAMPLE, lp, rp, lt, rt);
  endtask

  initial begin
    int phase_idle [4] = '{0, 84, 0, 20};
    int phase_stall [4] = '{0, 0, 84, 20};
    board = new();
    board.clear();
    send_idle = 0; recv_stall = 0; items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, snap edges, zero left scale, gain saturation, zero gains
    send_item(ITEM_TICK, 0, 0, 0, 0);
    send_item(ITEM_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_item(ITEM_SAMPLE, 100, 100, 102, 97);
    send_item(ITEM_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_item(ITEM_TICK, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(ITEM_SAMPLE, -1000, 1000, -1000, 1000);
    send_item(ITEM_TICK, 0, 0, 0, 0);
    drain();
    write_reg(REG_LEFT_MAX, 24'd0);
    write_reg(REG_RIGHT_MAX, 24'd32767);
    write_reg(REG_HEAD_GAIN, 24'hFFFFFF);
    write_reg(REG_TRAVEL_GAIN, 24'hFFFFFF);
    write_reg(REG_SNAP_WINDOW, 24'd15);
    write_reg(REG_NONE, 24'h123456);
    send_item(ITEM_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FF0, 16'sh7FF0);
    send_item(ITEM_SAMPLE, 16'sh8000, -5, 16'sh8000, 10);
    send_item(ITEM_TICK, 0, 0, 0, 0);
    repeat (3) send_item(ITEM_SAMPLE, 16'sh7FFF, 16'sh7FFF, 0, 0);
    send_item(ITEM_TICK, 0, 0, 0, 0);
    send_item(ITEM_TICK, 0, 0, 0, 0);
    drain();
    write_reg(REG_HEAD_GAIN, 24'd0);
    write_reg(REG_TRAVEL_GAIN, 24'd0);
    write_reg(REG_SNAP_WINDOW, 24'd0);
    send_item(ITEM_SAMPLE, 5, 6, 5, 7);
    send_item(ITEM_TICK, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle = phase_idle[ph % 4];
      recv_stall = phase_stall[ph % 4];
      random_config(ph % 3 == 1);
      for (int k = 0; k < 235; k++) random_item();
      send_item(ITEM_TICK, 0, 0, 0, 0);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("tb: %0d items sent, %0d poses checked over idle/stall phases and configs",
             items_sent, board.ticks);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== differential_drive_odometry_core.f =====
rtl/odo_pkg.sv
rtl/odo_front.sv
rtl/odo_fifo.sv
rtl/odo_back.sv
rtl/differential_drive_odometry_core.sv
rtl/odo_checker.sv
tb/tb.sv
